// ===== sv/ime_pkg.sv =====
// ime_pkg: shared constants and codes for the integer matrix engine.
// No dependencies; imported by integer_matrix_engine.
`default_nettype none

package ime_pkg;

  // Sizing defaults and fixed field widths
  localparam int DEF_MAX_DIM  = 8;
  localparam int ELEM_WIDTH   = 32;
  localparam int SEL_W        = 3;
  localparam int DIM_W        = 4;
  localparam int IN_TDATA_W   = 40;
  localparam int OUT_TDATA_W  = 40;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;

  // Request kinds (s_axis_tuser)
  localparam logic [1:0] FN_WR_A    = 2'd0;
  localparam logic [1:0] FN_WR_B    = 2'd1;
  localparam logic [1:0] FN_COMPUTE = 2'd2;

  // Operation modes
  localparam logic [1:0] MODE_MUL   = 2'd0;
  localparam logic [1:0] MODE_ADD   = 2'd1;
  localparam logic [1:0] MODE_SCALE = 2'd2;

  // Result status (m_axis_tuser)
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ROW_ERR = 2'd1;
  localparam logic [1:0] ST_COL_ERR = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OP_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_A  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE   = 3'd4;

endpackage

`default_nettype wire

// ===== sv/integer_matrix_engine.sv =====
// integer_matrix_engine: two element stores, a shared multiply/add unit and
// its sequencer, stream ports and a configuration write port. Uses ime_pkg.
`default_nettype none

// The engine keeps matrices A and B (up to MAX_DIM by MAX_DIM signed 32-bit
// elements, zero after reset) and serves one request at a time. A write
// request stores one element if it lies within the shape and returns one
// status item. A compute request walks the result in row-major order, one
// element after another, and tlast marks the final one. In product mode each
// result element takes one store read and one multiply-accumulate on the
// shared unit per term, then the read and multiply pipeline drains and the
// element is emitted; sum and scale mode take a single term per element.
// The engine is not ready during a compute; a finished item waits in the
// output register while the next request is taken. Results wrap modulo 2^32.
// Dimension registers read as 0 act as 1 and values above MAX_DIM act as
// MAX_DIM.
// Configuration must only be written while the engine is idle.
module integer_matrix_engine
  import ime_pkg::*;
#(
  parameter int MAX_DIM = DEF_MAX_DIM
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // Request stream
  input  wire logic                   s_axis_tvalid,
  output      logic                   s_axis_tready,
  // [2:0] row_sel, [5:3] col_sel, [37:6] elem_value, [39:38] zero
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [1:0] func
  input  wire logic [1:0]             s_axis_tuser,
  // Result stream
  output      logic                   m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // [2:0] out_row, [5:3] out_col, [37:6] result_value, [39:38] zero
  output      logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // [1:0] status
  output      logic [1:0]             m_axis_tuser,
  output      logic                   m_axis_tlast,
  // Configuration writes
  input  wire logic                   cfg_valid_i,
  output      logic                   cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IDXW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MAC   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  // Clamp a dimension register into 1..MAX_DIM
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    if (d == '0) begin
      r = DIM_W'(1);
    end else if (d > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = d;
    end
    return r;
  endfunction

  // Configuration registers
  logic [1:0]            op_mode_q;
  logic [DIM_W-1:0]      rows_a_q, cols_a_q, cols_b_q;
  logic [ELEM_WIDTH-1:0] scale_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_mode_q <= MODE_MUL;
      rows_a_q  <= DIM_W'(1);
      cols_a_q  <= DIM_W'(1);
      cols_b_q  <= DIM_W'(1);
      scale_q   <= ELEM_WIDTH'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_OP_MODE: op_mode_q <= cfg_data_i[1:0];
        CFG_ROWS_A:  rows_a_q  <= cfg_data_i[DIM_W-1:0];
        CFG_COLS_A:  cols_a_q  <= cfg_data_i[DIM_W-1:0];
        CFG_COLS_B:  cols_b_q  <= cfg_data_i[DIM_W-1:0];
        CFG_SCALE:   scale_q   <= cfg_data_i[ELEM_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Effective shapes
  logic [DIM_W-1:0] ra, ca, cb, nc;
  logic             is_mul;
  assign ra     = eff_dim(rows_a_q);
  assign ca     = eff_dim(cols_a_q);
  assign cb     = eff_dim(cols_b_q);
  assign is_mul = (op_mode_q == MODE_MUL);
  assign nc     = is_mul ? cb : ca;

  // Request fields
  logic [SEL_W-1:0]      in_row, in_col;
  logic [ELEM_WIDTH-1:0] in_val;
  logic                  in_acc;
  assign in_row = s_axis_tdata[SEL_W-1:0];
  assign in_col = s_axis_tdata[2*SEL_W-1:SEL_W];
  assign in_val = s_axis_tdata[2*SEL_W+ELEM_WIDTH-1:2*SEL_W];
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // Sequencer state
  logic [1:0]            state_q, state_d;
  logic [IDXW-1:0]       i_q, i_d, j_q, j_d, k_q, k_d;
  logic                  cmp_q, cmp_d;
  logic [SEL_W-1:0]      pend_row_q, pend_row_d, pend_col_q, pend_col_d;
  logic [1:0]            pend_st_q, pend_st_d;
  logic                  acc_clr;
  logic                  we_a, we_b;
  logic                  rd_vld_d, rd_last_d;
  logic                  out_load;

  // Write bounds and shape checks
  logic [DIM_W-1:0] lim_r, lim_c;
  logic [1:0]       wr_st;
  logic             k_last, j_last, i_last;

  assign lim_r  = (s_axis_tuser == FN_WR_A) ? ra : ca;
  assign lim_c  = (s_axis_tuser == FN_WR_A) ? ca : cb;
  assign k_last = (DIM_W'(k_q) + DIM_W'(1)) == ca;
  assign j_last = (DIM_W'(j_q) + DIM_W'(1)) == nc;
  assign i_last = (DIM_W'(i_q) + DIM_W'(1)) == ra;

  always_comb begin
    if (DIM_W'(in_row) >= lim_r) begin
      wr_st = ST_ROW_ERR;
    end else if (DIM_W'(in_col) >= lim_c) begin
      wr_st = ST_COL_ERR;
    end else begin
      wr_st = ST_OK;
    end
  end

  // Pipeline flags (read stage and multiply stage)
  logic rd_vld_q, rd_last_q, p_vld_q, p_last_q;

  always_comb begin
    state_d    = state_q;
    i_d        = i_q;
    j_d        = j_q;
    k_d        = k_q;
    cmp_d      = cmp_q;
    pend_row_d = pend_row_q;
    pend_col_d = pend_col_q;
    pend_st_d  = pend_st_q;
    acc_clr    = 1'b0;
    we_a       = 1'b0;
    we_b       = 1'b0;
    rd_vld_d   = 1'b0;
    rd_last_d  = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (s_axis_tuser) inside
            FN_WR_A, FN_WR_B: begin
              we_a       = (wr_st == ST_OK) && (s_axis_tuser == FN_WR_A);
              we_b       = (wr_st == ST_OK) && (s_axis_tuser == FN_WR_B);
              pend_row_d = in_row;
              pend_col_d = in_col;
              pend_st_d  = wr_st;
              cmp_d      = 1'b0;
              state_d    = S_EMIT;
            end
            FN_COMPUTE: begin
              pend_row_d = '0;
              pend_col_d = '0;
              cmp_d      = 1'b0;
              if ((op_mode_q == MODE_ADD) && (ra != ca)) begin
                pend_st_d = ST_ROW_ERR;
                state_d   = S_EMIT;
              end else if ((op_mode_q == MODE_ADD) && (ca != cb)) begin
                pend_st_d = ST_COL_ERR;
                state_d   = S_EMIT;
              end else if (op_mode_q != MODE_MUL && op_mode_q != MODE_ADD &&
                           op_mode_q != MODE_SCALE) begin
                state_d = S_IDLE;
              end else begin
                i_d     = '0;
                j_d     = '0;
                k_d     = '0;
                cmp_d   = 1'b1;
                acc_clr = 1'b1;
                state_d = S_MAC;
              end
            end
            default: ;
          endcase
        end
      end
      // Issue one term read per cycle
      S_MAC: begin
        rd_vld_d  = 1'b1;
        rd_last_d = !is_mul || k_last;
        if (is_mul && !k_last) begin
          k_d = k_q + IDXW'(1);
        end else begin
          k_d     = '0;
          state_d = S_DRAIN;
        end
      end
      // Wait until the final term is accumulated
      S_DRAIN: begin
        if (p_vld_q && p_last_q) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load = 1'b1;
          if (!cmp_q || (i_last && j_last)) begin
            state_d = S_IDLE;
          end else begin
            acc_clr = 1'b1;
            state_d = S_MAC;
            if (j_last) begin
              j_d = '0;
              i_d = i_q + IDXW'(1);
            end else begin
              j_d = j_q + IDXW'(1);
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign s_axis_tready = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      i_q       <= '0;
      j_q       <= '0;
      k_q       <= '0;
      cmp_q     <= 1'b0;
      rd_vld_q  <= 1'b0;
      rd_last_q <= 1'b0;
      p_vld_q   <= 1'b0;
      p_last_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      i_q       <= i_d;
      j_q       <= j_d;
      k_q       <= k_d;
      cmp_q     <= cmp_d;
      rd_vld_q  <= rd_vld_d;
      rd_last_q <= rd_last_d;
      p_vld_q   <= rd_vld_q;
      p_last_q  <= rd_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_row_q <= pend_row_d;
    pend_col_q <= pend_col_d;
    pend_st_q  <= pend_st_d;
  end

  // Element stores with per-entry valid bits; invalid entries read as zero
  logic [ELEM_WIDTH-1:0] mem_a [DEPTH];
  logic [ELEM_WIDTH-1:0] mem_b [DEPTH];
  logic [DEPTH-1:0]      va_q, vb_q;
  logic [ADDRW-1:0]      wr_addr, addr_a, addr_b;
  logic [ELEM_WIDTH-1:0] rd_a_q, rd_b_q;
  logic                  rva_q, rvb_q;

  assign wr_addr = ADDRW'(ADDRW'(in_row) * ADDRW'(MAX_DIM)) + ADDRW'(in_col);
  assign addr_a  = ADDRW'(ADDRW'(i_q) * ADDRW'(MAX_DIM))
                 + ADDRW'(is_mul ? k_q : j_q);
  assign addr_b  = ADDRW'(ADDRW'(is_mul ? k_q : i_q) * ADDRW'(MAX_DIM))
                 + ADDRW'(j_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= '0;
      vb_q <= '0;
    end else begin
      if (we_a) va_q[wr_addr] <= 1'b1;
      if (we_b) vb_q[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_a) mem_a[wr_addr] <= in_val;
    rd_a_q <= mem_a[addr_a];
    rva_q  <= va_q[addr_a];
  end

  always_ff @(posedge clk_i) begin
    if (we_b) mem_b[wr_addr] <= in_val;
    rd_b_q <= mem_b[addr_b];
    rvb_q  <= vb_q[addr_b];
  end

  // Shared arithmetic unit: multiply or add, then accumulate
  logic [ELEM_WIDTH-1:0] opa, opb, prod_q, acc_q;
  assign opa = rva_q ? rd_a_q : '0;
  assign opb = (op_mode_q == MODE_SCALE) ? scale_q : (rvb_q ? rd_b_q : '0);

  always_ff @(posedge clk_i) begin
    if (op_mode_q == MODE_ADD) begin
      prod_q <= opa + opb;
    end else begin
      prod_q <= ELEM_WIDTH'(opa * opb);
    end
    if (acc_clr) begin
      acc_q <= '0;
    end else if (p_vld_q) begin
      acc_q <= acc_q + prod_q;
    end
  end

  // Output register
  logic                  m_vld_q;
  logic [SEL_W-1:0]      o_row_q, o_col_q;
  logic [ELEM_WIDTH-1:0] o_val_q;
  logic [1:0]            o_st_q;
  logic                  o_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else begin
      m_vld_q <= out_load || (m_vld_q && !m_axis_tready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (cmp_q) begin
        o_row_q  <= SEL_W'(i_q);
        o_col_q  <= SEL_W'(j_q);
        o_val_q  <= acc_q;
        o_st_q   <= ST_OK;
        o_last_q <= i_last && j_last;
      end else begin
        o_row_q  <= pend_row_q;
        o_col_q  <= pend_col_q;
        o_val_q  <= '0;
        o_st_q   <= pend_st_q;
        o_last_q <= 1'b1;
      end
    end
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = {2'b00, o_val_q, o_col_q, o_row_q};
  assign m_axis_tuser  = o_st_q;
  assign m_axis_tlast  = o_last_q;

  // Checks
  a_emit_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> (!rd_vld_q && !p_vld_q))
    else $error("result emitted with terms still in flight");

  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we_a || we_b) |-> (state_q == S_IDLE && in_acc))
    else $error("store written outside an accepted request");

  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MAC) |-> (DIM_W'(k_q) < ca && DIM_W'(i_q) < ra && DIM_W'(j_q) < nc))
    else $error("term counter out of range");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != ST_OK) |-> m_axis_tlast)
    else $error("error status without tlast");

endmodule

`default_nettype wire

// ===== tb/tb_integer_matrix_engine.sv =====
`timescale 1ns / 1ps
// tb_integer_matrix_engine: self-checking bench for the integer matrix engine.
// Predicts every result item from its own copy of both stores and registers.
// Depends on ime_pkg and integer_matrix_engine only.

module tb_integer_matrix_engine
  import ime_pkg::*;
();

  localparam int MAX_DIM = DEF_MAX_DIM;
  // Codes with no operation behind them; the engine must stay silent
  localparam logic [1:0] FN_NONE   = 2'd3;
  localparam logic [1:0] MODE_NONE = 2'd3;
  // Idle time before a register write when a request may still be running
  localparam int QUIET_SHORT = 4;
  localparam int QUIET_LONG  = 800;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_REQS = 360;

  typedef struct packed {
    logic [2:0]  row;
    logic [2:0]  col;
    logic [31:0] value;
    logic [1:0]  status;
    logic        last;
  } mat_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // [2:0] row_sel, [5:3] col_sel, [37:6] elem_value, [39:38] zero
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  // [1:0] func
  logic [1:0]             s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // [2:0] out_row, [5:3] out_col, [37:6] result_value, [39:38] zero
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  // [1:0] status
  logic [1:0]             m_axis_tuser;
  logic                   m_axis_tlast;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i  = '0;

  // Predicted engine state
  logic [31:0] mat_a [MAX_DIM*MAX_DIM];
  logic [31:0] mat_b [MAX_DIM*MAX_DIM];
  logic [1:0]  reg_mode;
  logic [3:0]  reg_rows_a;
  logic [3:0]  reg_cols_a;
  logic [3:0]  reg_cols_b;
  logic [31:0] reg_scale;

  mat_result_t pending_results [$];
  mat_result_t head_result;
  int          fail_count     = 0;
  int          items_sent     = 0;
  bit          silent_sent    = 1'b0;
  bit          src_steady     = 1'b0;
  int          hold_token     = 0;
  int          hold_seen      = 0;
  int          hold_left      = 0;
  int          sink_wait      = 0;
  int          sink_burst     = 0;

  integer_matrix_engine #(
    .MAX_DIM(MAX_DIM)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // Random idle length: mostly none or short, now and then long
  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Element values weighted toward the corners of the signed range
  function automatic logic [31:0] rand_elem();
    case ($urandom_range(0, 9)) inside
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      4, 5: return $urandom_range(0, 15) - 8;
      default: return $urandom;
    endcase
  endfunction

  // Dimension register value as the engine reads it
  function automatic int unsigned clamp_dim(logic [3:0] d);
    if (d == 0) return 1;
    if (d > MAX_DIM) return MAX_DIM;
    return 32'(d);
  endfunction

  // Encoding of a dimension, sometimes through the clamped codes
  function automatic logic [3:0] code_dim(int unsigned d);
    if (d == 1 && $urandom_range(0, 3) == 0) return 4'd0;
    if (d == MAX_DIM && $urandom_range(0, 1) == 0) return 4'($urandom_range(9, 15));
    return 4'(d);
  endfunction

  function automatic void push_result(logic [2:0] r, logic [2:0] c, logic [31:0] v,
                                      logic [1:0] st, logic lst);
    pending_results.push_back('{row: r, col: c, value: v, status: st, last: lst});
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Matrix engine prediction for one accepted request
  task automatic predict_request(logic [1:0] fn, logic [2:0] r, logic [2:0] c,
                                 logic [31:0] v);
    int unsigned ra, ca, cb, lim_r, lim_c, nr, nc, i, j, k;
    logic [31:0] acc;
    logic [1:0]  st;
    ra = clamp_dim(reg_rows_a);
    ca = clamp_dim(reg_cols_a);
    cb = clamp_dim(reg_cols_b);
    if (fn == FN_WR_A || fn == FN_WR_B) begin
      // A is bounded by rows_a x cols_a, B by cols_a x cols_b; row checked first
      lim_r = (fn == FN_WR_A) ? ra : ca;
      lim_c = (fn == FN_WR_A) ? ca : cb;
      if (r >= lim_r) begin
        st = ST_ROW_ERR;
      end else if (c >= lim_c) begin
        st = ST_COL_ERR;
      end else begin
        st = ST_OK;
        if (fn == FN_WR_A) mat_a[r*MAX_DIM + c] = v;
        else mat_b[r*MAX_DIM + c] = v;
      end
      push_result(r, c, 32'd0, st, 1'b1);
      return;
    end
    if (fn != FN_COMPUTE || reg_mode == MODE_NONE) begin
      silent_sent = 1'b1;
      return;
    end
    // Sum needs B shaped like A
    if (reg_mode == MODE_ADD && ra != ca) begin
      push_result(3'd0, 3'd0, 32'd0, ST_ROW_ERR, 1'b1);
      return;
    end
    if (reg_mode == MODE_ADD && ca != cb) begin
      push_result(3'd0, 3'd0, 32'd0, ST_COL_ERR, 1'b1);
      return;
    end
    nr = ra;
    nc = (reg_mode == MODE_MUL) ? cb : ca;
    for (i = 0; i < nr; i++) begin
      for (j = 0; j < nc; j++) begin
        acc = 32'd0;
        if (reg_mode == MODE_MUL) begin
          for (k = 0; k < ca; k++)
            acc = acc + mat_a[i*MAX_DIM + k] * mat_b[k*MAX_DIM + j];
        end else if (reg_mode == MODE_ADD) begin
          acc = mat_a[i*MAX_DIM + j] + mat_b[i*MAX_DIM + j];
        end else begin
          acc = mat_a[i*MAX_DIM + j] * reg_scale;
        end
        push_result(3'(i), 3'(j), acc, ST_OK, (i + 1 == nr) && (j + 1 == nc));
      end
    end
  endtask

  // Offer one request, wait for acceptance, predict, then maybe idle
  task automatic send_req(logic [1:0] fn, logic [2:0] r, logic [2:0] c, logic [31:0] v);
    int unsigned pause;
    int          depth_was;
    s_axis_tuser  <= fn;
    s_axis_tdata  <= {2'b00, v, c, r};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    depth_was = pending_results.size();
    predict_request(fn, r, c, v);
    if (pending_results.size() > depth_was) items_sent++;
    pause = src_steady ? 0 : gap_len();
    if (pause != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (pause) @(posedge clk_i);
    end
  endtask

  // Wait until the engine has answered everything and gone idle
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (silent_sent ? QUIET_LONG : QUIET_SHORT) @(posedge clk_i);
    silent_sent = 1'b0;
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_OP_MODE: reg_mode   = data[1:0];
      CFG_ROWS_A:  reg_rows_a = data[3:0];
      CFG_COLS_A:  reg_cols_a = data[3:0];
      CFG_COLS_B:  reg_cols_b = data[3:0];
      CFG_SCALE:   reg_scale  = data;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic configure(logic [1:0] mode, logic [3:0] ra, logic [3:0] ca,
                           logic [3:0] cb, logic [31:0] scale);
    settle();
    cfg_write(CFG_OP_MODE, {30'd0, mode});
    cfg_write(CFG_ROWS_A, {28'd0, ra});
    cfg_write(CFG_COLS_A, {28'd0, ca});
    cfg_write(CFG_COLS_B, {28'd0, cb});
    cfg_write(CFG_SCALE, scale);
  endtask

  // Cleared stores, 1x1 shapes, product mode, bounds at the reset shape
  task automatic test_reset_defaults();
    send_req(FN_COMPUTE, 3'd0, 3'd0, 32'd0);
    send_req(FN_WR_A, 3'd0, 3'd0, 32'h7fff_ffff);
    send_req(FN_WR_B, 3'd0, 3'd0, 32'h8000_0000);
    send_req(FN_WR_A, 3'd7, 3'd7, 32'hffff_ffff);
    send_req(FN_WR_B, 3'd0, 3'd7, 32'h1234_5678);
    send_req(FN_COMPUTE, 3'd7, 3'd7, 32'hffff_ffff);
  endtask

  // Zero reads as one and codes above the maximum read as the maximum
  task automatic test_dim_clamp();
    configure(MODE_MUL, 4'd0, 4'd15, 4'd9, 32'd1);
    send_req(FN_WR_A, 3'd0, 3'd7, 32'h8000_0000);
    send_req(FN_WR_B, 3'd7, 3'd5, 32'hffff_ffff);
    send_req(FN_WR_B, 3'd7, 3'd7, 32'h7fff_ffff);
    send_req(FN_WR_A, 3'd1, 3'd0, 32'h0000_0001);
    send_req(FN_COMPUTE, 3'd2, 3'd5, 32'h5555_5555);
  endtask

  // Row test before column test; B rows bounded by cols_a
  task automatic test_write_bounds();
    configure(MODE_MUL, 4'd2, 4'd2, 4'd2, 32'd1);
    send_req(FN_WR_A, 3'd5, 3'd6, 32'haaaa_aaaa);
    send_req(FN_WR_B, 3'd1, 3'd3, 32'h0000_0007);
    send_req(FN_WR_B, 3'd3, 3'd1, 32'h0000_0007);
    send_req(FN_WR_A, 3'd1, 3'd1, 32'h5555_5555);
    send_req(FN_COMPUTE, 3'd0, 3'd0, 32'd0);
  endtask

  // Sum shape errors, sum, scale at the extremes, unused mode and function
  task automatic test_operations();
    configure(MODE_ADD, 4'd2, 4'd3, 4'd3, 32'd1);
    send_req(FN_COMPUTE, 3'd0, 3'd0, 32'd0);
    configure(MODE_ADD, 4'd3, 4'd3, 4'd2, 32'd1);
    send_req(FN_COMPUTE, 3'd0, 3'd0, 32'd0);
    configure(MODE_ADD, 4'd2, 4'd2, 4'd2, 32'd1);
    send_req(FN_COMPUTE, 3'd0, 3'd0, 32'd0);
    configure(MODE_SCALE, 4'd2, 4'd2, 4'd2, 32'h8000_0000);
    send_req(FN_COMPUTE, 3'd0, 3'd0, 32'd0);
    settle();
    cfg_write(CFG_SCALE, 32'hffff_ffff);
    send_req(FN_COMPUTE, 3'd0, 3'd0, 32'd0);
    configure(MODE_NONE, 4'd2, 4'd2, 4'd2, 32'h7fff_ffff);
    send_req(FN_COMPUTE, 3'd0, 3'd0, 32'd0);
    send_req(FN_NONE, 3'd7, 3'd7, 32'hffff_ffff);
  endtask

  // Result side held off while computes keep arriving back to back
  task automatic test_backpressure();
    configure(MODE_SCALE, 4'd4, 4'd4, 4'd4, rand_elem());
    src_steady = 1'b1;
    hold_token++;
    repeat (6) send_req(FN_COMPUTE, 3'($urandom), 3'($urandom), $urandom);
    settle();
    src_steady = 1'b0;
  endtask

  // Writes to one store over its shape, with stray requests mixed in
  task automatic fill_store(logic [1:0] fn, int unsigned nr, int unsigned nc);
    int unsigned r, c;
    for (r = 0; r < nr; r++) begin
      for (c = 0; c < nc; c++) begin
        if ($urandom_range(0, 9) == 0)
          send_req(2'($urandom_range(0, 3)), 3'($urandom), 3'($urandom), rand_elem());
        if ($urandom_range(0, 9) < 7)
          send_req(fn, 3'(r), 3'(c), rand_elem());
      end
    end
  endtask

  // Random phases: pick a setting, load the stores, compute
  task automatic test_random_phases();
    int          start;
    int unsigned pick, ra, ca, cb;
    bit          big;
    logic [1:0]  mode;
    logic [31:0] scale;
    start = items_sent;
    while (items_sent - start < RANDOM_REQS) begin
      src_steady = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 19);
      mode = (pick < 9) ? MODE_MUL : (pick < 14) ? MODE_ADD :
             (pick < 19) ? MODE_SCALE : MODE_NONE;
      big = ($urandom_range(0, 9) == 0);
      ra = big ? MAX_DIM : $urandom_range(1, 4);
      ca = big ? MAX_DIM : $urandom_range(1, 4);
      cb = big ? MAX_DIM : $urandom_range(1, 4);
      if (mode == MODE_ADD && $urandom_range(0, 4) != 0) begin
        ca = ra;
        cb = ra;
      end
      scale = ($urandom_range(0, 3) == 0) ? $urandom : rand_elem();
      configure(mode, code_dim(ra), code_dim(ca), code_dim(cb), scale);
      fill_store(FN_WR_A, ra, ca);
      fill_store(FN_WR_B, ca, cb);
      repeat ($urandom_range(1, 2))
        send_req(FN_COMPUTE, 3'($urandom), 3'($urandom), $urandom);
    end
    src_steady = 1'b0;
  endtask

  // Result checker and result-side ready pattern
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: row %0d col %0d value 0x%0h status %0d",
               m_axis_tdata[2:0], m_axis_tdata[5:3], m_axis_tdata[37:6], m_axis_tuser);
        fail_count++;
      end else begin
        head_result = pending_results.pop_front();
        check_field("out_row", 32'(head_result.row), 32'(m_axis_tdata[2:0]));
        check_field("out_col", 32'(head_result.col), 32'(m_axis_tdata[5:3]));
        check_field("result_value", head_result.value, m_axis_tdata[37:6]);
        check_field("status", 32'(head_result.status), 32'(m_axis_tuser));
        check_field("last", 32'(head_result.last), 32'(m_axis_tlast));
      end
    end
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES - 1;
      m_axis_tready <= 1'b0;
    end else if (sink_wait > 0) begin
      m_axis_tready <= 1'b0;
      sink_wait--;
    end else if (sink_burst > 0) begin
      m_axis_tready <= 1'b1;
      sink_burst--;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 19) == 0) sink_burst = $urandom_range(50, 200);
      else sink_wait = gap_len();
    end
  end

  initial begin
    for (int n = 0; n < MAX_DIM*MAX_DIM; n++) begin
      mat_a[n] = 32'd0;
      mat_b[n] = 32'd0;
    end
    reg_mode   = MODE_MUL;
    reg_rows_a = 4'd1;
    reg_cols_a = 4'd1;
    reg_cols_b = 4'd1;
    reg_scale  = 32'd1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_dim_clamp();
    test_write_bounds();
    test_operations();
    test_backpressure();
    test_random_phases();
    settle();
    repeat (QUIET_LONG) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_integer_matrix_engine passed");
    end else begin
      $display("tb_integer_matrix_engine failed");
    end
    $finish;
  end

  // Run limit
  initial begin
    #20_000_000;
    $display("tb_integer_matrix_engine failed");
    $finish;
  end

endmodule
